@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the execute unit RTL.
// Each macro assumes signals named clk and arst_n in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_ALWAYS(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("cpu65 assertion failed");
`define ASSERT_NEXT(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("cpu65 assertion failed");
`else
`define ASSERT_ALWAYS(label, prop)
`define ASSERT_NEXT(label, pre, post)
`endif
`endif

@@ rtl/core/cpu65_pkg.sv @@
// Types, operation codes and reset constants of the 6502 execute unit.
// Used by cpu65_alu, cpu65_regfile and cpu6502_execute_unit; no dependencies.
package cpu65_pkg;

	// Architectural register set
	typedef struct packed {
		logic [7:0] a;
		logic [7:0] x;
		logic [7:0] y;
		logic [7:0] p;
		logic [7:0] s;
	} regs_t;

	// Per-item side results
	typedef struct packed {
		logic [7:0] data;
		logic       write;
		logic [7:0] slot;
		logic       taken;
	} res_t;

	localparam logic [7:0] P_RESET  = 8'h24;
	localparam logic [7:0] SP_RESET = 8'hFD;

	// Status bit positions
	localparam int FLAG_C = 0;
	localparam int FLAG_Z = 1;
	localparam int FLAG_I = 2;
	localparam int FLAG_D = 3;
	localparam int FLAG_B = 4;
	localparam int FLAG_U = 5;
	localparam int FLAG_V = 6;
	localparam int FLAG_N = 7;

	localparam logic [6:0] FN_LDA = 7'd0;
	localparam logic [6:0] FN_LDX = 7'd1;
	localparam logic [6:0] FN_LDY = 7'd2;
	localparam logic [6:0] FN_STA = 7'd3;
	localparam logic [6:0] FN_STX = 7'd4;
	localparam logic [6:0] FN_STY = 7'd5;
	localparam logic [6:0] FN_TAX = 7'd6;
	localparam logic [6:0] FN_TAY = 7'd7;
	localparam logic [6:0] FN_TXA = 7'd8;
	localparam logic [6:0] FN_TYA = 7'd9;
	localparam logic [6:0] FN_TSX = 7'd10;
	localparam logic [6:0] FN_TXS = 7'd11;
	localparam logic [6:0] FN_PHA = 7'd12;
	localparam logic [6:0] FN_PHP = 7'd13;
	localparam logic [6:0] FN_PLA = 7'd14;
	localparam logic [6:0] FN_PLP = 7'd15;
	localparam logic [6:0] FN_AND = 7'd16;
	localparam logic [6:0] FN_ORA = 7'd17;
	localparam logic [6:0] FN_EOR = 7'd18;
	localparam logic [6:0] FN_BIT = 7'd19;
	localparam logic [6:0] FN_ADC = 7'd20;
	localparam logic [6:0] FN_SBC = 7'd21;
	localparam logic [6:0] FN_CMP = 7'd22;
	localparam logic [6:0] FN_CPX = 7'd23;
	localparam logic [6:0] FN_CPY = 7'd24;
	localparam logic [6:0] FN_INC = 7'd25;
	localparam logic [6:0] FN_DEC = 7'd26;
	localparam logic [6:0] FN_INX = 7'd27;
	localparam logic [6:0] FN_INY = 7'd28;
	localparam logic [6:0] FN_DEX = 7'd29;
	localparam logic [6:0] FN_DEY = 7'd30;
	localparam logic [6:0] FN_ASL_A = 7'd31;
	localparam logic [6:0] FN_ASL_M = 7'd32;
	localparam logic [6:0] FN_LSR_A = 7'd33;
	localparam logic [6:0] FN_LSR_M = 7'd34;
	localparam logic [6:0] FN_ROL_A = 7'd35;
	localparam logic [6:0] FN_ROL_M = 7'd36;
	localparam logic [6:0] FN_ROR_A = 7'd37;
	localparam logic [6:0] FN_ROR_M = 7'd38;
	localparam logic [6:0] FN_LAX = 7'd39;
	localparam logic [6:0] FN_SAX = 7'd40;
	localparam logic [6:0] FN_DCP = 7'd41;
	localparam logic [6:0] FN_ISB = 7'd42;
	localparam logic [6:0] FN_SLO = 7'd43;
	localparam logic [6:0] FN_RLA = 7'd44;
	localparam logic [6:0] FN_SRE = 7'd45;
	localparam logic [6:0] FN_RRA = 7'd46;
	localparam logic [6:0] FN_CLC = 7'd47;
	localparam logic [6:0] FN_SEC = 7'd48;
	localparam logic [6:0] FN_CLI = 7'd49;
	localparam logic [6:0] FN_SEI = 7'd50;
	localparam logic [6:0] FN_CLD = 7'd51;
	localparam logic [6:0] FN_SED = 7'd52;
	localparam logic [6:0] FN_CLV = 7'd53;
	localparam logic [6:0] FN_BCC = 7'd54;
	localparam logic [6:0] FN_BCS = 7'd55;
	localparam logic [6:0] FN_BNE = 7'd56;
	localparam logic [6:0] FN_BEQ = 7'd57;
	localparam logic [6:0] FN_BPL = 7'd58;
	localparam logic [6:0] FN_BMI = 7'd59;
	localparam logic [6:0] FN_BVC = 7'd60;
	localparam logic [6:0] FN_BVS = 7'd61;
	localparam logic [6:0] FN_BRK = 7'd62;
	localparam logic [6:0] FN_NMI = 7'd63;
	localparam logic [6:0] FN_IRQ = 7'd64;
	localparam logic [6:0] FN_NOP = 7'd65;
	localparam logic [6:0] FN_PUSH = 7'd66;
	localparam logic [6:0] FN_PULL = 7'd67;

endpackage

@@ rtl/core/cpu65_regfile.sv @@
// Architectural registers A, X, Y, P and S of the execute unit.
// Depends on cpu65_pkg for regs_t and reset constants.
module cpu65_regfile (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              we,
	input  cpu65_pkg::regs_t  nxt,
	output cpu65_pkg::regs_t  cur
);

	cpu65_pkg::regs_t regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.a <= 8'h00;
			regs_q.x <= 8'h00;
			regs_q.y <= 8'h00;
			regs_q.p <= cpu65_pkg::P_RESET;
			regs_q.s <= cpu65_pkg::SP_RESET;
		end else if (we) begin
			regs_q <= nxt;
		end
	end

	assign cur = regs_q;

endmodule

@@ rtl/core/cpu65_alu.sv @@
// Combinational ALU and flag logic: next register set and side results of one item.
// Depends on cpu65_pkg for types, operation codes and flag positions.
module cpu65_alu (
	input  cpu65_pkg::regs_t  cur,
	input  logic [6:0]        func,
	input  logic [7:0]        operand,
	output cpu65_pkg::regs_t  nxt,
	output cpu65_pkg::res_t   res
);

	// Update N and Z from a result byte
	function automatic logic [7:0] with_nz(input logic [7:0] p, input logic [7:0] v);
		logic [7:0] r;
		r = p;
		r[cpu65_pkg::FLAG_Z] = (v == 8'h00);
		r[cpu65_pkg::FLAG_N] = v[7];
		return r;
	endfunction

	// Add with carry: returns {new status, sum}
	function automatic logic [15:0] add_c(input logic [7:0] a, input logic [7:0] b,
			input logic [7:0] p);
		logic [8:0] sum;
		logic [7:0] r;
		logic [7:0] np;
		sum = {1'b0, a} + {1'b0, b} + {8'h00, p[cpu65_pkg::FLAG_C]};
		r = sum[7:0];
		np = p;
		np[cpu65_pkg::FLAG_C] = sum[8];
		np[cpu65_pkg::FLAG_V] = ~(a[7] ^ b[7]) & (a[7] ^ r[7]);
		np = with_nz(np, r);
		return {np, r};
	endfunction

	// Compare r against v
	function automatic logic [7:0] cmp_p(input logic [7:0] r, input logic [7:0] v,
			input logic [7:0] p);
		logic [8:0] diff;
		logic [7:0] np;
		diff = {1'b0, r} + {1'b0, ~v} + 9'd1;
		np = p;
		np[cpu65_pkg::FLAG_C] = diff[8];
		return with_nz(np, diff[7:0]);
	endfunction

	// Shift or rotate: sel 0 ASL, 1 LSR, 2 ROL, 3 ROR; returns {new status, byte}
	function automatic logic [15:0] shift(input logic [1:0] sel, input logic [7:0] v,
			input logic [7:0] p);
		logic [7:0] r;
		logic       c;
		logic [7:0] np;
		case (sel)
			2'd0: begin r = {v[6:0], 1'b0}; c = v[7]; end
			2'd1: begin r = {1'b0, v[7:1]}; c = v[0]; end
			2'd2: begin r = {v[6:0], p[cpu65_pkg::FLAG_C]}; c = v[7]; end
			default: begin r = {p[cpu65_pkg::FLAG_C], v[7:1]}; c = v[0]; end
		endcase
		np = p;
		np[cpu65_pkg::FLAG_C] = c;
		np = with_nz(np, r);
		return {np, r};
	endfunction

	logic [15:0] t;
	logic [15:0] u;
	logic [7:0]  m;

	always_comb begin
		nxt = cur;
		res = '0;
		t = 16'h0000;
		u = 16'h0000;
		m = 8'h00;
		case (func)
			cpu65_pkg::FN_LDA: begin nxt.a = operand; nxt.p = with_nz(cur.p, operand); end
			cpu65_pkg::FN_LDX: begin nxt.x = operand; nxt.p = with_nz(cur.p, operand); end
			cpu65_pkg::FN_LDY: begin nxt.y = operand; nxt.p = with_nz(cur.p, operand); end
			cpu65_pkg::FN_STA: begin res.data = cur.a; res.write = 1'b1; end
			cpu65_pkg::FN_STX: begin res.data = cur.x; res.write = 1'b1; end
			cpu65_pkg::FN_STY: begin res.data = cur.y; res.write = 1'b1; end
			cpu65_pkg::FN_TAX: begin nxt.x = cur.a; nxt.p = with_nz(cur.p, cur.a); end
			cpu65_pkg::FN_TAY: begin nxt.y = cur.a; nxt.p = with_nz(cur.p, cur.a); end
			cpu65_pkg::FN_TXA: begin nxt.a = cur.x; nxt.p = with_nz(cur.p, cur.x); end
			cpu65_pkg::FN_TYA: begin nxt.a = cur.y; nxt.p = with_nz(cur.p, cur.y); end
			cpu65_pkg::FN_TSX: begin nxt.x = cur.s; nxt.p = with_nz(cur.p, cur.s); end
			cpu65_pkg::FN_TXS: nxt.s = cur.x;
			cpu65_pkg::FN_PHA: begin
				res.data = cur.a; res.write = 1'b1; res.slot = cur.s;
				nxt.s = cur.s - 8'd1;
			end
			cpu65_pkg::FN_PHP: begin
				res.data = cur.p | 8'h30; res.write = 1'b1; res.slot = cur.s;
				nxt.s = cur.s - 8'd1;
			end
			cpu65_pkg::FN_PLA: begin
				nxt.s = cur.s + 8'd1; res.slot = cur.s + 8'd1;
				nxt.a = operand; nxt.p = with_nz(cur.p, operand);
			end
			cpu65_pkg::FN_PLP: begin
				nxt.s = cur.s + 8'd1; res.slot = cur.s + 8'd1;
				// drop B, force U
				nxt.p = (operand & 8'hEF) | 8'h20;
			end
			cpu65_pkg::FN_AND: begin
				nxt.a = cur.a & operand; nxt.p = with_nz(cur.p, cur.a & operand);
			end
			cpu65_pkg::FN_ORA: begin
				nxt.a = cur.a | operand; nxt.p = with_nz(cur.p, cur.a | operand);
			end
			cpu65_pkg::FN_EOR: begin
				nxt.a = cur.a ^ operand; nxt.p = with_nz(cur.p, cur.a ^ operand);
			end
			cpu65_pkg::FN_BIT: begin
				nxt.p[cpu65_pkg::FLAG_Z] = ((cur.a & operand) == 8'h00);
				nxt.p[cpu65_pkg::FLAG_V] = operand[6];
				nxt.p[cpu65_pkg::FLAG_N] = operand[7];
			end
			cpu65_pkg::FN_ADC: begin
				t = add_c(cur.a, operand, cur.p); nxt.a = t[7:0]; nxt.p = t[15:8];
			end
			cpu65_pkg::FN_SBC: begin
				t = add_c(cur.a, ~operand, cur.p); nxt.a = t[7:0]; nxt.p = t[15:8];
			end
			cpu65_pkg::FN_CMP: nxt.p = cmp_p(cur.a, operand, cur.p);
			cpu65_pkg::FN_CPX: nxt.p = cmp_p(cur.x, operand, cur.p);
			cpu65_pkg::FN_CPY: nxt.p = cmp_p(cur.y, operand, cur.p);
			cpu65_pkg::FN_INC: begin
				m = operand + 8'd1; res.data = m; res.write = 1'b1;
				nxt.p = with_nz(cur.p, m);
			end
			cpu65_pkg::FN_DEC: begin
				m = operand - 8'd1; res.data = m; res.write = 1'b1;
				nxt.p = with_nz(cur.p, m);
			end
			cpu65_pkg::FN_INX: begin
				nxt.x = cur.x + 8'd1; nxt.p = with_nz(cur.p, cur.x + 8'd1);
			end
			cpu65_pkg::FN_INY: begin
				nxt.y = cur.y + 8'd1; nxt.p = with_nz(cur.p, cur.y + 8'd1);
			end
			cpu65_pkg::FN_DEX: begin
				nxt.x = cur.x - 8'd1; nxt.p = with_nz(cur.p, cur.x - 8'd1);
			end
			cpu65_pkg::FN_DEY: begin
				nxt.y = cur.y - 8'd1; nxt.p = with_nz(cur.p, cur.y - 8'd1);
			end
			cpu65_pkg::FN_ASL_A: begin
				t = shift(2'd0, cur.a, cur.p); nxt.a = t[7:0]; nxt.p = t[15:8];
			end
			cpu65_pkg::FN_ASL_M: begin
				t = shift(2'd0, operand, cur.p); res.data = t[7:0]; res.write = 1'b1;
				nxt.p = t[15:8];
			end
			cpu65_pkg::FN_LSR_A: begin
				t = shift(2'd1, cur.a, cur.p); nxt.a = t[7:0]; nxt.p = t[15:8];
			end
			cpu65_pkg::FN_LSR_M: begin
				t = shift(2'd1, operand, cur.p); res.data = t[7:0]; res.write = 1'b1;
				nxt.p = t[15:8];
			end
			cpu65_pkg::FN_ROL_A: begin
				t = shift(2'd2, cur.a, cur.p); nxt.a = t[7:0]; nxt.p = t[15:8];
			end
			cpu65_pkg::FN_ROL_M: begin
				t = shift(2'd2, operand, cur.p); res.data = t[7:0]; res.write = 1'b1;
				nxt.p = t[15:8];
			end
			cpu65_pkg::FN_ROR_A: begin
				t = shift(2'd3, cur.a, cur.p); nxt.a = t[7:0]; nxt.p = t[15:8];
			end
			cpu65_pkg::FN_ROR_M: begin
				t = shift(2'd3, operand, cur.p); res.data = t[7:0]; res.write = 1'b1;
				nxt.p = t[15:8];
			end
			cpu65_pkg::FN_LAX: begin
				nxt.a = operand; nxt.x = operand; nxt.p = with_nz(cur.p, operand);
			end
			cpu65_pkg::FN_SAX: begin res.data = cur.a & cur.x; res.write = 1'b1; end
			cpu65_pkg::FN_DCP: begin
				m = operand - 8'd1; res.data = m; res.write = 1'b1;
				nxt.p = cmp_p(cur.a, m, cur.p);
			end
			cpu65_pkg::FN_ISB: begin
				m = operand + 8'd1; res.data = m; res.write = 1'b1;
				t = add_c(cur.a, ~m, cur.p); nxt.a = t[7:0]; nxt.p = t[15:8];
			end
			cpu65_pkg::FN_SLO: begin
				t = shift(2'd0, operand, cur.p); res.data = t[7:0]; res.write = 1'b1;
				nxt.a = cur.a | t[7:0]; nxt.p = with_nz(t[15:8], cur.a | t[7:0]);
			end
			cpu65_pkg::FN_RLA: begin
				t = shift(2'd2, operand, cur.p); res.data = t[7:0]; res.write = 1'b1;
				nxt.a = cur.a & t[7:0]; nxt.p = with_nz(t[15:8], cur.a & t[7:0]);
			end
			cpu65_pkg::FN_SRE: begin
				t = shift(2'd1, operand, cur.p); res.data = t[7:0]; res.write = 1'b1;
				nxt.a = cur.a ^ t[7:0]; nxt.p = with_nz(t[15:8], cur.a ^ t[7:0]);
			end
			cpu65_pkg::FN_RRA: begin
				// add uses the carry left by the rotate
				t = shift(2'd3, operand, cur.p); res.data = t[7:0]; res.write = 1'b1;
				u = add_c(cur.a, t[7:0], t[15:8]); nxt.a = u[7:0]; nxt.p = u[15:8];
			end
			cpu65_pkg::FN_CLC: nxt.p[cpu65_pkg::FLAG_C] = 1'b0;
			cpu65_pkg::FN_SEC: nxt.p[cpu65_pkg::FLAG_C] = 1'b1;
			cpu65_pkg::FN_CLI: nxt.p[cpu65_pkg::FLAG_I] = 1'b0;
			cpu65_pkg::FN_SEI: nxt.p[cpu65_pkg::FLAG_I] = 1'b1;
			cpu65_pkg::FN_CLD: nxt.p[cpu65_pkg::FLAG_D] = 1'b0;
			cpu65_pkg::FN_SED: nxt.p[cpu65_pkg::FLAG_D] = 1'b1;
			cpu65_pkg::FN_CLV: nxt.p[cpu65_pkg::FLAG_V] = 1'b0;
			cpu65_pkg::FN_BCC: res.taken = ~cur.p[cpu65_pkg::FLAG_C];
			cpu65_pkg::FN_BCS: res.taken = cur.p[cpu65_pkg::FLAG_C];
			cpu65_pkg::FN_BNE: res.taken = ~cur.p[cpu65_pkg::FLAG_Z];
			cpu65_pkg::FN_BEQ: res.taken = cur.p[cpu65_pkg::FLAG_Z];
			cpu65_pkg::FN_BPL: res.taken = ~cur.p[cpu65_pkg::FLAG_N];
			cpu65_pkg::FN_BMI: res.taken = cur.p[cpu65_pkg::FLAG_N];
			cpu65_pkg::FN_BVC: res.taken = ~cur.p[cpu65_pkg::FLAG_V];
			cpu65_pkg::FN_BVS: res.taken = cur.p[cpu65_pkg::FLAG_V];
			cpu65_pkg::FN_BRK: begin
				res.data = cur.p | 8'h30; res.write = 1'b1; res.slot = cur.s;
				res.taken = 1'b1;
				nxt.s = cur.s - 8'd1; nxt.p[cpu65_pkg::FLAG_I] = 1'b1;
			end
			cpu65_pkg::FN_NMI: begin
				res.data = (cur.p & 8'hEF) | 8'h20; res.write = 1'b1; res.slot = cur.s;
				res.taken = 1'b1;
				nxt.s = cur.s - 8'd1; nxt.p[cpu65_pkg::FLAG_I] = 1'b1;
			end
			cpu65_pkg::FN_IRQ: begin
				// masked request leaves everything untouched
				if (!cur.p[cpu65_pkg::FLAG_I]) begin
					res.data = (cur.p & 8'hEF) | 8'h20; res.write = 1'b1;
					res.slot = cur.s; res.taken = 1'b1;
					nxt.s = cur.s - 8'd1; nxt.p[cpu65_pkg::FLAG_I] = 1'b1;
				end
			end
			cpu65_pkg::FN_PUSH: begin
				res.data = operand; res.write = 1'b1; res.slot = cur.s;
				nxt.s = cur.s - 8'd1;
			end
			cpu65_pkg::FN_PULL: begin
				nxt.s = cur.s + 8'd1; res.slot = cur.s + 8'd1;
			end
			default: ;
		endcase
	end

endmodule

@@ rtl/core/cpu6502_execute_unit.sv @@
// Execute unit of a 6502 without decimal mode: input stage, ALU, register file, result stage.
// Depends on cpu65_pkg, cpu65_alu, cpu65_regfile and assert_macros.svh.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one decoded operation (func) and the
//   byte already fetched for it (operand). Output channel (out_valid/out_ready)
//   returns exactly one result item per input item, in order: the byte to write or
//   push, its write strobe, the stack slot used, the branch/interrupt taken flag and
//   the full register set A, X, Y, P, S after the operation.
//   An accepted item is held in the input register, then goes through the ALU into the
//   result register, which raises out_valid; while the result register stalls, the item
//   waits in the input register. Throughput is one item per cycle while out_ready stays
//   high; the register file updates at the edge where an item moves from the input
//   register into the result register, so each item sees all earlier ones.
//   When the receiver stalls, the result register holds; the input register still
//   takes one more item, then in_ready drops until the result is taken.
//   Reset (arst_n low) empties both stages and sets A=X=Y=0, P=0x24, S=0xFD.
`include "assert_macros.svh"

module cpu6502_execute_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [6:0] func,
	input  logic [7:0] operand,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] data_out,
	output logic       write_out,
	output logic [7:0] stack_slot,
	output logic       taken,
	output logic [7:0] acc_out,
	output logic [7:0] xreg_out,
	output logic [7:0] yreg_out,
	output logic [7:0] status_out,
	output logic [7:0] sp_out
);

	logic             valid_s1;
	logic [6:0]       func_s1;
	logic [7:0]       operand_s1;
	logic             out_valid_q;
	cpu65_pkg::regs_t regs_q;
	cpu65_pkg::res_t  res_q;
	cpu65_pkg::regs_t cur;
	cpu65_pkg::regs_t nxt;
	cpu65_pkg::res_t  res;
	logic             advance;

	// Move an item into the result register when that register is free or draining
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			func_s1    <= func;
			operand_s1 <= operand;
		end
	end

	cpu65_alu u_alu (
		.cur     (cur),
		.func    (func_s1),
		.operand (operand_s1),
		.nxt     (nxt),
		.res     (res)
	);

	cpu65_regfile u_regfile (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (advance),
		.nxt    (nxt),
		.cur    (cur)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q  <= res;
			regs_q <= nxt;
		end
	end

	assign out_valid  = out_valid_q;
	assign data_out   = res_q.data;
	assign write_out  = res_q.write;
	assign stack_slot = res_q.slot;
	assign taken      = res_q.taken;
	assign acc_out    = regs_q.a;
	assign xreg_out   = regs_q.x;
	assign yreg_out   = regs_q.y;
	assign status_out = regs_q.p;
	assign sp_out     = regs_q.s;

	`ASSERT_ALWAYS(a_u_flag_set, out_valid_q |-> status_out[cpu65_pkg::FLAG_U])
	`ASSERT_ALWAYS(a_no_write_zero, (out_valid_q && !write_out) |-> (data_out == 8'h00))
	`ASSERT_ALWAYS(a_entry_push, (out_valid_q && taken && write_out) |-> (sp_out == stack_slot - 8'd1))
	`ASSERT_NEXT(a_s1_hold, (valid_s1 && !advance), valid_s1)

endmodule

@@ sim/cpu6502_execute_unit_tb.sv @@
`timescale 1ns / 100ps
// Self-checking bench for cpu6502_execute_unit: drives decoded operations with random gaps
// and stalls, and checks every result against an in-bench model of A, X, Y, P and S.
// Depends on cpu65_pkg and the execute unit RTL.
module cpu6502_execute_unit_tb;
	import cpu65_pkg::*;

	localparam logic [6:0] FN_FIRST_UNUSED = 7'd68;
	localparam logic [6:0] FN_LAST_UNUSED  = 7'd127;
	localparam int RANDOM_ITEMS   = 1750;
	localparam int QUIET_TAIL     = 200;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int REPORT_LIMIT   = 10;

	typedef struct packed {
		res_t  side;
		regs_t regs;
	} outcome_t;

	class execute_tracker;
		logic [7:0] acc, xr, yr, pf, sp;
		outcome_t   pending_results[$];
		int unsigned failures;

		function new();
			acc = '0;
			xr = '0;
			yr = '0;
			pf = P_RESET;
			sp = SP_RESET;
			failures = 0;
		endfunction

		function void set_nz(logic [7:0] v);
			pf[FLAG_Z] = (v == 8'h00);
			pf[FLAG_N] = v[7];
		endfunction

		function void add_with_carry(logic [7:0] v);
			logic [8:0] sum;
			sum = {1'b0, acc} + {1'b0, v} + {8'h00, pf[FLAG_C]};
			pf[FLAG_C] = sum[8];
			pf[FLAG_V] = ~(acc[7] ^ v[7]) & (acc[7] ^ sum[7]);
			acc = sum[7:0];
			set_nz(acc);
		endfunction

		function void compare(logic [7:0] r, logic [7:0] v);
			pf[FLAG_C] = (r >= v);
			set_nz(r - v);
		endfunction

		function logic [7:0] shift_up(logic [7:0] v, logic cin);
			logic [7:0] r;
			r = {v[6:0], cin};
			pf[FLAG_C] = v[7];
			set_nz(r);
			return r;
		endfunction

		function logic [7:0] shift_down(logic [7:0] v, logic cin);
			logic [7:0] r;
			r = {cin, v[7:1]};
			pf[FLAG_C] = v[0];
			set_nz(r);
			return r;
		endfunction

		function void push(inout res_t side, input logic [7:0] b);
			side.data = b;
			side.write = 1'b1;
			side.slot = sp;
			sp = sp - 8'h01;
		endfunction

		function logic [7:0] status_image(logic brk);
			logic [7:0] b;
			b = pf;
			b[FLAG_B] = brk;
			b[FLAG_U] = 1'b1;
			return b;
		endfunction

		function void enter_interrupt(inout res_t side, input logic brk);
			push(side, status_image(brk));
			pf[FLAG_I] = 1'b1;
			side.taken = 1'b1;
		endfunction

		function outcome_t predict_op(logic [6:0] f, logic [7:0] v);
			res_t       side;
			logic [7:0] m;
			outcome_t   o;
			side = '0;
			case (f)
				FN_LDA: begin acc = v; set_nz(v); end
				FN_LDX: begin xr = v; set_nz(v); end
				FN_LDY: begin yr = v; set_nz(v); end
				FN_STA: begin side.data = acc; side.write = 1'b1; end
				FN_STX: begin side.data = xr; side.write = 1'b1; end
				FN_STY: begin side.data = yr; side.write = 1'b1; end
				FN_TAX: begin xr = acc; set_nz(xr); end
				FN_TAY: begin yr = acc; set_nz(yr); end
				FN_TXA: begin acc = xr; set_nz(acc); end
				FN_TYA: begin acc = yr; set_nz(acc); end
				FN_TSX: begin xr = sp; set_nz(xr); end
				FN_TXS: sp = xr;
				FN_PHA: push(side, acc);
				FN_PHP: push(side, status_image(1'b1));
				FN_PLA: begin
					sp = sp + 8'h01;
					side.slot = sp;
					acc = v;
					set_nz(v);
				end
				FN_PLP: begin
					sp = sp + 8'h01;
					side.slot = sp;
					pf = v;
					pf[FLAG_B] = 1'b0;
					pf[FLAG_U] = 1'b1;
				end
				FN_AND: begin acc = acc & v; set_nz(acc); end
				FN_ORA: begin acc = acc | v; set_nz(acc); end
				FN_EOR: begin acc = acc ^ v; set_nz(acc); end
				FN_BIT: begin
					pf[FLAG_Z] = ((acc & v) == 8'h00);
					pf[FLAG_V] = v[6];
					pf[FLAG_N] = v[7];
				end
				FN_ADC: add_with_carry(v);
				FN_SBC: add_with_carry(~v);
				FN_CMP: compare(acc, v);
				FN_CPX: compare(xr, v);
				FN_CPY: compare(yr, v);
				FN_INC: begin side.data = v + 8'h01; side.write = 1'b1; set_nz(side.data); end
				FN_DEC: begin side.data = v - 8'h01; side.write = 1'b1; set_nz(side.data); end
				FN_INX: begin xr = xr + 8'h01; set_nz(xr); end
				FN_INY: begin yr = yr + 8'h01; set_nz(yr); end
				FN_DEX: begin xr = xr - 8'h01; set_nz(xr); end
				FN_DEY: begin yr = yr - 8'h01; set_nz(yr); end
				FN_ASL_A: acc = shift_up(acc, 1'b0);
				FN_ASL_M: begin side.data = shift_up(v, 1'b0); side.write = 1'b1; end
				FN_LSR_A: acc = shift_down(acc, 1'b0);
				FN_LSR_M: begin side.data = shift_down(v, 1'b0); side.write = 1'b1; end
				FN_ROL_A: acc = shift_up(acc, pf[FLAG_C]);
				FN_ROL_M: begin side.data = shift_up(v, pf[FLAG_C]); side.write = 1'b1; end
				FN_ROR_A: acc = shift_down(acc, pf[FLAG_C]);
				FN_ROR_M: begin side.data = shift_down(v, pf[FLAG_C]); side.write = 1'b1; end
				FN_LAX: begin acc = v; xr = v; set_nz(v); end
				FN_SAX: begin side.data = acc & xr; side.write = 1'b1; end
				FN_DCP: begin
					m = v - 8'h01;
					side.data = m;
					side.write = 1'b1;
					compare(acc, m);
				end
				FN_ISB: begin
					m = v + 8'h01;
					side.data = m;
					side.write = 1'b1;
					add_with_carry(~m);
				end
				FN_SLO: begin
					m = shift_up(v, 1'b0);
					side.data = m;
					side.write = 1'b1;
					acc = acc | m;
					set_nz(acc);
				end
				FN_RLA: begin
					m = shift_up(v, pf[FLAG_C]);
					side.data = m;
					side.write = 1'b1;
					acc = acc & m;
					set_nz(acc);
				end
				FN_SRE: begin
					m = shift_down(v, 1'b0);
					side.data = m;
					side.write = 1'b1;
					acc = acc ^ m;
					set_nz(acc);
				end
				FN_RRA: begin
					m = shift_down(v, pf[FLAG_C]);
					side.data = m;
					side.write = 1'b1;
					add_with_carry(m);
				end
				FN_CLC: pf[FLAG_C] = 1'b0;
				FN_SEC: pf[FLAG_C] = 1'b1;
				FN_CLI: pf[FLAG_I] = 1'b0;
				FN_SEI: pf[FLAG_I] = 1'b1;
				FN_CLD: pf[FLAG_D] = 1'b0;
				FN_SED: pf[FLAG_D] = 1'b1;
				FN_CLV: pf[FLAG_V] = 1'b0;
				FN_BCC: side.taken = !pf[FLAG_C];
				FN_BCS: side.taken = pf[FLAG_C];
				FN_BNE: side.taken = !pf[FLAG_Z];
				FN_BEQ: side.taken = pf[FLAG_Z];
				FN_BPL: side.taken = !pf[FLAG_N];
				FN_BMI: side.taken = pf[FLAG_N];
				FN_BVC: side.taken = !pf[FLAG_V];
				FN_BVS: side.taken = pf[FLAG_V];
				FN_BRK: enter_interrupt(side, 1'b1);
				FN_NMI: enter_interrupt(side, 1'b0);
				// masked IRQ leaves everything alone
				FN_IRQ: if (!pf[FLAG_I]) enter_interrupt(side, 1'b0);
				FN_PUSH: push(side, v);
				FN_PULL: begin sp = sp + 8'h01; side.slot = sp; end
				default: ;
			endcase
			o.side = side;
			o.regs = '{a: acc, x: xr, y: yr, p: pf, s: sp};
			return o;
		endfunction

		function void note_op(logic [6:0] f, logic [7:0] v);
			pending_results.push_back(predict_op(f, v));
		endfunction

		function void report_field(string name, logic [7:0] want, logic [7:0] got);
			if (want !== got) begin
				failures++;
				if (failures <= REPORT_LIMIT)
					$display("%0t: %s mismatch: expected %02h, got %02h", $realtime, name, want, got);
			end
		endfunction

		function void check_result(outcome_t got);
			outcome_t want;
			if (pending_results.size() == 0) begin
				failures++;
				if (failures <= REPORT_LIMIT)
					$display("%0t: result with no item outstanding", $realtime);
				return;
			end
			want = pending_results.pop_front();
			report_field("data_out", want.side.data, got.side.data);
			report_field("write_out", {7'd0, want.side.write}, {7'd0, got.side.write});
			report_field("stack_slot", want.side.slot, got.side.slot);
			report_field("taken", {7'd0, want.side.taken}, {7'd0, got.side.taken});
			report_field("acc_out", want.regs.a, got.regs.a);
			report_field("xreg_out", want.regs.x, got.regs.x);
			report_field("yreg_out", want.regs.y, got.regs.y);
			report_field("status_out", want.regs.p, got.regs.p);
			report_field("sp_out", want.regs.s, got.regs.s);
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [6:0] func = FN_NOP;
	logic [7:0] operand = 8'h00;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] data_out;
	logic       write_out;
	logic [7:0] stack_slot;
	logic       taken;
	logic [7:0] acc_out;
	logic [7:0] xreg_out;
	logic [7:0] yreg_out;
	logic [7:0] status_out;
	logic [7:0] sp_out;

	execute_tracker tracker = new();
	int unsigned    idle_rate = 3;    // chance of a gap out of 16; 0 means none
	int unsigned    quiet_cycles = 0;

	cpu6502_execute_unit i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.func       (func),
		.operand    (operand),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.data_out   (data_out),
		.write_out  (write_out),
		.stack_slot (stack_slot),
		.taken      (taken),
		.acc_out    (acc_out),
		.xreg_out   (xreg_out),
		.yreg_out   (yreg_out),
		.status_out (status_out),
		.sp_out     (sp_out)
	);

	always #10 clk = ~clk;

	// Handshake monitor and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				tracker.check_result('{
					side: '{data: data_out, write: write_out, slot: stack_slot, taken: taken},
					regs: '{a: acc_out, x: xreg_out, y: yreg_out, p: status_out, s: sp_out}});
			if (in_valid && in_ready)
				tracker.note_op(func, operand);
			if ((out_valid && out_ready) || (in_valid && in_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
				$display("Regression FAIL");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// Receiver: stall in random bursts
	initial begin
		forever begin
			@(posedge clk);
			if (idle_rate != 0 && $urandom_range(1, 16) <= idle_rate) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(posedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	// Call at a rising edge; returns at the edge where the item is taken, valid still high.
	task automatic send_item(input logic [6:0] f, input logic [7:0] v);
		if (idle_rate != 0 && $urandom_range(1, 16) <= idle_rate) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		operand <= v;
		do @(posedge clk); while (!in_ready);
	endtask

	// Hold the input until every outstanding result has come back
	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (tracker.pending_results.size() != 0);
	endtask

	function automatic logic [7:0] pick_operand();
		case ($urandom_range(0, 11))
			0: return 8'h00;
			1: return 8'hFF;
			2: return 8'h7F;
			3: return 8'h80;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	initial begin
		int unsigned counted;
		int unsigned next_phase;
		logic [6:0]  f;
		counted = 0;
		next_phase = 250;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// stack wrap both ways, status pull, masked and accepted interrupts
		send_item(FN_LDX, 8'h00);
		send_item(FN_TXS, 8'h00);
		send_item(FN_PHA, 8'h00);
		send_item(FN_PULL, 8'h00);
		send_item(FN_PLP, 8'hFF);
		send_item(FN_IRQ, 8'h00);
		send_item(FN_CLI, 8'h00);
		send_item(FN_IRQ, 8'h00);
		send_item(FN_BRK, 8'h00);
		send_item(FN_NMI, 8'h00);
		// arithmetic, read-modify-write, unused function codes and stack pushes at the edges
		send_item(FN_LDA, 8'hFF);
		send_item(FN_ADC, 8'h01);
		send_item(FN_SBC, 8'h80);
		send_item(FN_INC, 8'hFF);
		send_item(FN_DEC, 8'h00);
		send_item(FN_FIRST_UNUSED, 8'hFF);
		send_item(FN_LAST_UNUSED, 8'h55);
		send_item(FN_ROR_M, 8'h01);
		send_item(FN_BIT, 8'hC0);
		send_item(FN_LAX, 8'h80);
		send_item(FN_SAX, 8'h00);
		send_item(FN_ISB, 8'hFF);
		send_item(FN_RRA, 8'hFF);
		send_item(FN_PUSH, 8'hFF);
		send_item(FN_PHP, 8'h00);
		drain_results();

		while (counted < RANDOM_ITEMS) begin
			if (counted >= next_phase) begin
				next_phase += 250;
				idle_rate = $urandom_range(0, 4);
				if (counted % 500 < 250)
					drain_results();
			end
			if (counted + QUIET_TAIL >= RANDOM_ITEMS)
				idle_rate = 0;
			if ($urandom_range(0, 3) == 0) begin
				// load, ALU op, then a branch on the flags it left
				send_item(7'($urandom_range(FN_LDA, FN_LDY)), pick_operand());
				send_item(7'($urandom_range(FN_AND, FN_CPY)), pick_operand());
				send_item(7'($urandom_range(FN_BCC, FN_BVS)), pick_operand());
				counted += 3;
			end else begin
				if ($urandom_range(0, 9) == 0)
					f = 7'($urandom_range(FN_FIRST_UNUSED, FN_LAST_UNUSED));
				else
					f = 7'($urandom_range(FN_LDA, FN_PULL));
				send_item(f, pick_operand());
				if (f <= FN_PULL && f != FN_NOP)
					counted++;
			end
		end

		drain_results();
		repeat (8) @(posedge clk);
		if (tracker.failures == 0 && tracker.pending_results.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
